>>> src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert fail");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("assert fail");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

>>> src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants of the first-fit pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ffpa_pkg;
  localparam int POOL_ADDR_BITS = 16;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic                      op;
    logic [POOL_ADDR_BITS:0]   request_size;
    logic [POOL_ADDR_BITS-1:0] free_offset;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [POOL_ADDR_BITS-1:0] granted_offset;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_EDIT, S_MERGE_NEXT, S_MERGE_PREV, S_DONE
  } state_t;

  // Shift command to all cells
  typedef enum logic [1:0] {SH_HOLD, SH_UP, SH_DOWN} shift_t;

  typedef struct packed {
    logic       init;
    shift_t     shift;
    logic       wr_en;
  } cell_ctl_t;
endpackage

>>> src/ffpa_cell.sv
// ----------------------------------------------------------------------------
// ffpa_cell
// One table entry: holds a segment, compares it, shifts with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ffpa_cell #(
  parameter int LW = 17,
  parameter int AW = 16
) (
  input  logic              clk,
  input  ffpa_pkg::cell_ctl_t ctl,
  input  logic              is_first,
  input  logic [LW-1:0]     init_len,
  input  logic              sel_up,
  input  logic              sel_down,
  input  logic              sel_wr,
  input  logic [AW-1:0]     wr_start,
  input  logic [LW-1:0]     wr_len,
  input  logic              wr_free,
  input  logic [AW-1:0]     lo_start,
  input  logic [LW-1:0]     lo_len,
  input  logic              lo_free,
  input  logic [AW-1:0]     hi_start,
  input  logic [LW-1:0]     hi_len,
  input  logic              hi_free,
  input  logic [LW-1:0]     req,
  input  logic [AW-1:0]     ofs,
  output logic [AW-1:0]     start_o,
  output logic [LW-1:0]     len_o,
  output logic              free_o,
  output logic              fit_o,
  output logic              hit_o
);
  logic [AW-1:0] start_r;
  logic [LW-1:0] len_r;
  logic          free_r;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      start_r <= '0;
      len_r   <= is_first ? init_len : '0;
      free_r  <= is_first;
    end else if (ctl.wr_en && sel_wr) begin
      start_r <= wr_start;
      len_r   <= wr_len;
      free_r  <= wr_free;
    end else if (ctl.shift == ffpa_pkg::SH_UP && sel_up) begin
      start_r <= lo_start;
      len_r   <= lo_len;
      free_r  <= lo_free;
    end else if (ctl.shift == ffpa_pkg::SH_DOWN && sel_down) begin
      start_r <= hi_start;
      len_r   <= hi_len;
      free_r  <= hi_free;
    end
  end

  assign start_o = start_r;
  assign len_o   = len_r;
  assign free_o  = free_r;
  assign fit_o   = free_r && (len_r >= req);
  assign hit_o   = !free_r && (start_r == ofs);
endmodule

>>> src/first_fit_pool_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator over a chain of segment cells with split and coalesce.
//
//  channel | dir | handshake    | payload
//  in_     | in  | valid/stall  | in_beat_t (op, request_size, free_offset)
//  out_    | out | valid/stall  | out_beat_t (status, granted_offset)
//  cfg_    | in  | valid/ready  | pool_size
//
// One beat at a time. Before the result beat, an allocate or an unknown free
// passes the states MATCH, EDIT and DONE, a zero-size allocate MATCH and DONE,
// and a free that lands also MERGE_NEXT and MERGE_PREV: one state per step.
// At the soonest, the next input beat is taken in the cycle after the result is taken.
// A cfg write rebuilds the table at the clock edge that takes it. Reset is
// synchronous, stalls input and cfg, and leaves one free segment of 65536
// bytes. A stalled result holds; input waits until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_pool_allocator #(
  parameter int MAX_SEGMENTS   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ffpa_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ffpa_pkg::out_beat_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffpa_pkg::POOL_ADDR_BITS:0] cfg_pool_size
);
  localparam int N  = MAX_SEGMENTS;
  localparam int AW = ffpa_pkg::POOL_ADDR_BITS;
  localparam int LW = ffpa_pkg::POOL_ADDR_BITS + 1;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam logic [LW-1:0] POOL_MAX = LW'(1) << AW;

  ffpa_pkg::state_t state_r, state_nxt;
  ffpa_pkg::cell_ctl_t ctl;
  logic [LW-1:0] pool_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic          found_r, found_nxt;
  logic          op_r;
  logic [LW-1:0] req_r;
  logic [AW-1:0] ofs_r;
  ffpa_pkg::out_beat_t res_r, res_nxt;
  logic          out_valid_r;

  logic [AW-1:0] c_start [N];
  logic [LW-1:0] c_len   [N];
  logic          c_free  [N];
  logic [N-1:0]  c_fit, c_hit;
  logic [N-1:0]  sel_up, sel_down, sel_wr;
  logic [AW-1:0] wr_start [N];
  logic [LW-1:0] wr_len   [N];
  logic          wr_free  [N];
  logic [IW-1:0] pri_idx;
  logic          pri_any;
  logic          cfg_fire, in_fire;
  logic [LW-1:0] cfg_sat;

  assign cfg_ready = rst_n && (state_r == ffpa_pkg::S_IDLE) && !out_valid_r;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = !(rst_n && (state_r == ffpa_pkg::S_IDLE) && !out_valid_r && !cfg_valid);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_sat   = (cfg_pool_size > POOL_MAX) ? POOL_MAX : cfg_pool_size;

  // priority pick among valid cells
  always_comb begin
    pri_idx = '0;
    pri_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if ((op_r == ffpa_pkg::OP_FREE ? c_hit[i] : c_fit[i]) && (CW'(i) < count_r)) begin
        pri_idx = IW'(i);
        pri_any = 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ffpa_cell #(.LW(LW), .AW(AW)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .is_first (g == 0),
        .init_len ((!rst_n) ? POOL_MAX : cfg_sat),
        .sel_up   (sel_up[g]),
        .sel_down (sel_down[g]),
        .sel_wr   (sel_wr[g]),
        .wr_start (wr_start[g]),
        .wr_len   (wr_len[g]),
        .wr_free  (wr_free[g]),
        .lo_start ((g == 0) ? '0 : c_start[(g == 0) ? 0 : g-1]),
        .lo_len   ((g == 0) ? '0 : c_len[(g == 0) ? 0 : g-1]),
        .lo_free  ((g == 0) ? 1'b0 : c_free[(g == 0) ? 0 : g-1]),
        .hi_start ((g == N-1) ? '0 : c_start[(g == N-1) ? g : g+1]),
        .hi_len   ((g == N-1) ? '0 : c_len[(g == N-1) ? g : g+1]),
        .hi_free  ((g == N-1) ? 1'b0 : c_free[(g == N-1) ? g : g+1]),
        .req      (req_r),
        .ofs      (ofs_r),
        .start_o  (c_start[g]),
        .len_o    (c_len[g]),
        .free_o   (c_free[g]),
        .fit_o    (c_fit[g]),
        .hit_o    (c_hit[g])
      );
    end
  endgenerate

  logic [IW:0] hit_p1;
  logic [LW-1:0] hit_len, nb_len, pv_len;
  logic [AW-1:0] hit_start;
  logic nb_free, pv_free, has_nb, has_pv;
  assign hit_p1    = {1'b0, hit_r} + 1'b1;
  assign hit_len   = c_len[hit_r];
  assign hit_start = c_start[hit_r];
  assign has_nb    = (CW'(hit_p1) < count_r);
  assign nb_len    = has_nb ? c_len[hit_p1[IW-1:0]] : '0;
  assign nb_free   = has_nb && c_free[hit_p1[IW-1:0]];
  assign has_pv    = hit_r != '0;
  assign pv_len    = has_pv ? c_len[hit_r - 1'b1] : '0;
  assign pv_free   = has_pv && c_free[hit_r - 1'b1];

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    ctl.init  = !rst_n || cfg_fire;
    ctl.shift = ffpa_pkg::SH_HOLD;
    ctl.wr_en = 1'b0;
    sel_up = '0; sel_down = '0; sel_wr = '0;
    for (int i = 0; i < N; i++) begin
      wr_start[i] = c_start[i];
      wr_len[i]   = c_len[i];
      wr_free[i]  = c_free[i];
    end
    case (state_r)
      ffpa_pkg::S_IDLE: begin
        if (in_fire) state_nxt = ffpa_pkg::S_MATCH;
      end
      ffpa_pkg::S_MATCH: begin
        hit_nxt   = pri_idx;
        found_nxt = pri_any;
        state_nxt = ffpa_pkg::S_EDIT;
        res_nxt   = '{status: ffpa_pkg::ST_OK, granted_offset: '0};
        if (op_r == ffpa_pkg::OP_ALLOC && req_r == '0) begin
          res_nxt.status = ffpa_pkg::ST_ZERO;
          state_nxt = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_EDIT: begin
        state_nxt = ffpa_pkg::S_DONE;
        if (op_r == ffpa_pkg::OP_ALLOC) begin
          if (!found_r) res_nxt.status = ffpa_pkg::ST_NOFIT;
          else if (hit_len != req_r && count_r >= CW'(N)) res_nxt.status = ffpa_pkg::ST_FULL;
          else begin
            res_nxt.granted_offset = hit_start;
            ctl.wr_en = 1'b1;
            if (hit_len != req_r) begin
              ctl.shift = ffpa_pkg::SH_UP;
              count_nxt = count_r + 1'b1;
              for (int i = 0; i < N; i++) sel_up[i] = (i > hit_r + 1);
              if (CW'(hit_p1) < CW'(N)) begin
                sel_wr[hit_p1[IW-1:0]] = 1'b1;
                wr_start[hit_p1[IW-1:0]] = hit_start + AW'(req_r);
                wr_len[hit_p1[IW-1:0]]   = hit_len - req_r;
                wr_free[hit_p1[IW-1:0]]  = 1'b1;
              end
            end
            sel_wr[hit_r] = 1'b1;
            wr_start[hit_r] = hit_start;
            wr_len[hit_r]   = req_r;
            wr_free[hit_r]  = 1'b0;
          end
        end else if (!found_r) begin
          res_nxt.status = ffpa_pkg::ST_UNKNOWN;
        end else begin
          ctl.wr_en = 1'b1;
          sel_wr[hit_r] = 1'b1;
          wr_free[hit_r] = 1'b1;
          state_nxt = ffpa_pkg::S_MERGE_NEXT;
        end
      end
      ffpa_pkg::S_MERGE_NEXT: begin
        state_nxt = ffpa_pkg::S_MERGE_PREV;
        if (nb_free) begin
          ctl.wr_en = 1'b1;
          ctl.shift = ffpa_pkg::SH_DOWN;
          count_nxt = count_r - 1'b1;
          sel_wr[hit_r] = 1'b1;
          wr_len[hit_r] = hit_len + nb_len;
          for (int i = 0; i < N; i++) begin
            sel_down[i] = (i > hit_r) && (CW'(i) < count_r);
            if ((i > hit_r) && (CW'(i) == count_r - 1'b1)) begin
              sel_wr[i] = 1'b1;
              wr_start[i] = '0; wr_len[i] = '0; wr_free[i] = 1'b0;
            end
          end
        end
      end
      ffpa_pkg::S_MERGE_PREV: begin
        state_nxt = ffpa_pkg::S_DONE;
        if (pv_free) begin
          ctl.wr_en = 1'b1;
          ctl.shift = ffpa_pkg::SH_DOWN;
          count_nxt = count_r - 1'b1;
          sel_wr[hit_r - 1'b1] = 1'b1;
          wr_len[hit_r - 1'b1] = pv_len + hit_len;
          for (int i = 0; i < N; i++) begin
            sel_down[i] = (i >= hit_r) && (CW'(i) < count_r);
            if ((i >= hit_r) && (CW'(i) == count_r - 1'b1)) begin
              sel_wr[i] = 1'b1;
              wr_start[i] = '0; wr_len[i] = '0; wr_free[i] = 1'b0;
            end
          end
        end
      end
      ffpa_pkg::S_DONE: begin
        state_nxt = ffpa_pkg::S_IDLE;
      end
      default: state_nxt = ffpa_pkg::S_IDLE;
    endcase
    if (ctl.init) count_nxt = CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffpa_pkg::S_IDLE;
      count_r     <= CW'(1);
      pool_r      <= POOL_MAX;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      hit_r       <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
      if (cfg_fire) pool_r <= cfg_sat;
      if (state_r == ffpa_pkg::S_DONE) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_fire) begin
      op_r  <= in_data.op;
      req_r <= in_data.request_size;
      ofs_r <= in_data.free_offset;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `ASSERT_CLK(a_count_range, clk, rst_n, (count_r >= CW'(1)) && (count_r <= CW'(N)))
  `ASSERT_NEVER(a_in_while_busy, clk, rst_n, in_fire && (state_r != ffpa_pkg::S_IDLE))
  `ASSERT_CLK(a_done_valid, clk, rst_n, (state_r == ffpa_pkg::S_DONE) |=> out_valid_r)
  `ASSERT_CLK(a_pool_cap, clk, rst_n, pool_r <= POOL_MAX)
endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit pool allocator: a clocked driver
// feeds allocate/free beats from a pending queue, a clocked monitor compares
// each result beat with a segment-table model kept in the bench. Pool size
// changes between phases, including the extremes and an oversized value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  localparam int NSEG = 32;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ffpa_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffpa_pkg::out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [16:0] cfg_pool_size = '0;

  first_fit_pool_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_size(cfg_pool_size)
  );

  always #2 clk = ~clk;

  // allocator model
  logic [15:0] seg_start [NSEG];
  logic [16:0] seg_len [NSEG];
  logic        seg_free [NSEG];
  int          seg_count;
  logic [16:0] pool_bytes;

  ffpa_pkg::in_beat_t  pending_beats [$];
  ffpa_pkg::out_beat_t expected_results [$];
  logic [15:0] live_offsets [$];
  int  errors = 0;
  bit  quiet_tail = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  idle_cycles = 0;
  logic in_took = 1'b0;
  logic in_taken;

  function automatic void table_reset(input logic [16:0] sz);
    pool_bytes = (sz > 17'h10000) ? 17'h10000 : sz;
    for (int i = 0; i < NSEG; i++) begin
      seg_start[i] = '0;
      seg_len[i] = '0;
      seg_free[i] = 1'b0;
    end
    seg_len[0] = pool_bytes;
    seg_free[0] = 1'b1;
    seg_count = 1;
  endfunction

  function automatic void seg_remove(input int k);
    for (int i = k; i + 1 < seg_count; i++) begin
      seg_start[i] = seg_start[i + 1];
      seg_len[i] = seg_len[i + 1];
      seg_free[i] = seg_free[i + 1];
    end
    seg_count--;
    seg_start[seg_count] = '0;
    seg_len[seg_count] = '0;
    seg_free[seg_count] = 1'b0;
  endfunction

  function automatic ffpa_pkg::out_beat_t allocate_or_free(input ffpa_pkg::in_beat_t b);
    ffpa_pkg::out_beat_t r;
    int hit;
    r = '0;
    r.status = ffpa_pkg::ST_OK;
    hit = -1;
    if (b.op == ffpa_pkg::OP_ALLOC) begin
      if (b.request_size == 0) begin
        r.status = ffpa_pkg::ST_ZERO;
      end else begin
        for (int i = 0; i < seg_count; i++)
          if (hit < 0 && seg_free[i] && seg_len[i] >= b.request_size) hit = i;
        if (hit < 0) begin
          r.status = ffpa_pkg::ST_NOFIT;
        end else if (seg_len[hit] != b.request_size && seg_count >= NSEG) begin
          r.status = ffpa_pkg::ST_FULL;
        end else begin
          if (seg_len[hit] != b.request_size) begin
            for (int i = seg_count; i > hit + 1; i--) begin
              seg_start[i] = seg_start[i - 1];
              seg_len[i] = seg_len[i - 1];
              seg_free[i] = seg_free[i - 1];
            end
            seg_start[hit + 1] = seg_start[hit] + b.request_size[15:0];
            seg_len[hit + 1] = seg_len[hit] - b.request_size;
            seg_free[hit + 1] = 1'b1;
            seg_count++;
            seg_len[hit] = b.request_size;
          end
          seg_free[hit] = 1'b0;
          r.granted_offset = seg_start[hit];
        end
      end
    end else begin
      for (int i = 0; i < seg_count; i++)
        if (hit < 0 && !seg_free[i] && seg_start[i] == b.free_offset) hit = i;
      if (hit < 0) begin
        r.status = ffpa_pkg::ST_UNKNOWN;
      end else begin
        seg_free[hit] = 1'b1;
        if (hit + 1 < seg_count && seg_free[hit + 1]) begin
          seg_len[hit] += seg_len[hit + 1];
          seg_remove(hit + 1);
        end
        if (hit > 0 && seg_free[hit - 1]) begin
          seg_len[hit - 1] += seg_len[hit];
          seg_remove(hit);
        end
      end
    end
    return r;
  endfunction

  function automatic void add_beat(input ffpa_pkg::in_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  assign in_taken = in_valid && !in_stall;

  // predict each accepted beat
  always @(posedge clk) begin : predict
    ffpa_pkg::out_beat_t r;
    in_took <= rst_n && in_taken;
    if (rst_n && in_taken) begin
      r = allocate_or_free(in_data);
      expected_results.insert(expected_results.size(), r);
      if (in_data.op == ffpa_pkg::OP_ALLOC && r.status == ffpa_pkg::ST_OK)
        live_offsets.insert(live_offsets.size(), r.granted_offset);
    end
  end

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 19) == 0) in_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
      out_gap <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0d/%0h", $time,
                 out_data.status, out_data.granted_offset);
        errors++;
      end else begin
        ffpa_pkg::out_beat_t e;
        e = expected_results.pop_front();
        if (e.status != out_data.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (e.granted_offset != out_data.granted_offset) begin
          $display("%0t: offset expected %0h actual %0h", $time, e.granted_offset,
                   out_data.granted_offset);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic ffpa_pkg::in_beat_t alloc_beat(input logic [16:0] sz);
    ffpa_pkg::in_beat_t b;
    b.op = ffpa_pkg::OP_ALLOC;
    b.request_size = sz;
    b.free_offset = 16'($urandom);
    return b;
  endfunction

  function automatic ffpa_pkg::in_beat_t free_beat(input logic [15:0] ofs);
    ffpa_pkg::in_beat_t b;
    b.op = ffpa_pkg::OP_FREE;
    b.request_size = 17'($urandom);
    b.free_offset = ofs;
    return b;
  endfunction

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_pool(input logic [16:0] sz);
    @(negedge clk);
    cfg_pool_size <= sz;
    cfg_valid <= 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    table_reset(sz);
    live_offsets.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int max_req);
    ffpa_pkg::in_beat_t b;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        b = alloc_beat(17'($urandom_range(1, max_req)));
      end else if (k < 85 && live_offsets.size() > 0) begin
        int j;
        j = $urandom_range(0, live_offsets.size() - 1);
        b = free_beat(live_offsets[j]);
        live_offsets.delete(j);
      end else if (k < 90) begin
        b = alloc_beat(17'($urandom));
      end else if (k < 93) begin
        b = alloc_beat('0);
      end else begin
        b = free_beat(16'($urandom));
      end
      add_beat(b);
      // keep the live list tied to beats already predicted
      while (pending_beats.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    table_reset(17'h10000);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: extremes, zero size, no fit, double free, inside offset
    add_beat(alloc_beat('0));
    add_beat(alloc_beat(17'h10001));
    add_beat(alloc_beat(17'h1FFFF));
    add_beat(alloc_beat(17'h10000));
    add_beat(alloc_beat(17'd1));
    add_beat(free_beat(16'h0000));
    add_beat(free_beat(16'h0000));
    add_beat(alloc_beat(17'd100));
    add_beat(alloc_beat(17'd200));
    add_beat(alloc_beat(17'd300));
    add_beat(free_beat(16'd50));
    add_beat(free_beat(16'd100));
    add_beat(free_beat(16'd0));
    add_beat(free_beat(16'd300));
    add_beat(free_beat(16'hFFFF));
    add_beat(alloc_beat(17'hFFFF));
    drain();
    // table full: 31 small allocs leave 32 segments
    write_pool(17'd1000);
    for (int i = 0; i < 32; i++) add_beat(alloc_beat(17'd10));
    add_beat(alloc_beat(17'd690));
    add_beat(free_beat(16'd10));
    add_beat(free_beat(16'd20));
    add_beat(free_beat(16'd0));
    drain();
    write_pool(17'd0);
    add_beat(alloc_beat(17'd1));
    add_beat(alloc_beat('0));
    drain();
    write_pool(17'd1);
    add_beat(alloc_beat(17'd1));
    add_beat(alloc_beat(17'd1));
    add_beat(free_beat(16'd0));
    drain();
    write_pool(17'h1FFFF);
    random_phase(400, 8000);
    drain();
    write_pool(17'd4096);
    random_phase(400, 300);
    drain();
    write_pool(17'h10000);
    random_phase(400, 4000);
    drain();
    write_pool(17'd97);
    random_phase(200, 8);
    quiet_tail = 1'b1;
    random_phase(200, 20);
    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/ffpa_pkg.sv
src/ffpa_cell.sv
src/first_fit_pool_allocator.sv
tb/tb.sv
